### hdl/lca_pkg.sv
// shared types, constants and the b3/s23 rule for the life generation step core
// no dependencies; imported by the drain stage, the top level and the testbench
package lca_pkg;

  localparam int CNT_W   = 6;  // width of the row and column count registers
  localparam int POS_W   = 5;  // width of the emitted row and column fields
  localparam int MAX_ROWS = 32;
  localparam int NUM_RES = 4;  // results one item can cause

  localparam logic [CNT_W-1:0] MIN_DIM   = 6'd3;
  localparam logic [CNT_W-1:0] DIM_RESET = 6'd32;

  // register index, taken from paddr[2]
  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  // result slots of one item, emitted lowest first
  localparam int RES_MAIN       = 0;  // cell above-left of the input
  localparam int RES_BELOW      = 1;  // last row: cell left of the input
  localparam int RES_EDGE       = 2;  // last column: cell above the input
  localparam int RES_EDGE_BELOW = 3;  // last cell of the frame

  typedef logic [CNT_W-1:0] pos_t;

  typedef struct packed {
    logic [NUM_RES-1:0] mask;
    pos_t               row;
    pos_t               col;
  } step_t;

  // shift every window column down one row, dead row enters at the bottom
  function automatic logic [8:0] drop_row(input logic [8:0] w);
    return {w[7:6], 1'b0, w[4:3], 1'b0, w[1:0], 1'b0};
  endfunction

  // next state of the window center under b3/s23
  function automatic logic life_next(input logic [8:0] w);
    logic [3:0] n;
    n = '0;
    for (int k = 0; k < 9; k++) begin
      if (k != 4) n = n + 4'(w[k]);
    end
    return (n == 4'd3) || ((n == 4'd2) && w[4]);
  endfunction

endpackage

### hdl/lca_in_if.sv
// input channel of the life generation step core: one cell state per item
// no dependencies
interface lca_in_if;
  logic valid;
  logic ready;
  logic cell_alive;

  modport source (output valid, output cell_alive, input ready);
  modport sink   (input valid, input cell_alive, output ready);
endinterface

### hdl/lca_out_if.sv
// output channel of the life generation step core: next state plus coordinates
// no dependencies
interface lca_out_if;
  logic       valid;
  logic       ready;
  logic       next_alive;
  logic [4:0] out_row;
  logic [4:0] out_col;
  logic       frame_done;

  modport source (output valid, output next_alive, output out_row, output out_col,
                  output frame_done, input ready);
  modport sink   (input valid, input next_alive, input out_row, input out_col,
                  input frame_done, output ready);
endinterface

### hdl/lca_shift_cell.sv
// one cell of a shift chain: holds W bits and takes its neighbor's bits on shift
// no dependencies; used for the line chain and the 3x3 window columns
module lca_shift_cell #(
  parameter int W = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         shift,
  input  logic         clear,
  input  logic [W-1:0] din,
  output logic [W-1:0] q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= clear ? '0 : din;
    end
  end

endmodule

### hdl/lca_drain.sv
// holds the pending results of one item and hands them out one per cycle while out_cell is not stalled
// depends on lca_pkg and lca_out_if
module lca_drain
  import lca_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  step_t       step_in,
  input  logic [8:0]  window,
  output logic        step_ready,
  lca_out_if.source   out_cell
);

  step_t              step_q;
  logic               out_free;
  logic               take;
  logic [NUM_RES-1:0] low;
  logic [NUM_RES-1:0] mask_left;
  logic [8:0]         w_sel;
  pos_t               row_sel;
  pos_t               col_sel;
  logic               done_sel;

  assign out_free  = !out_cell.valid || out_cell.ready;
  assign take      = out_free && (step_q.mask != '0);
  assign low       = step_q.mask & (~step_q.mask + NUM_RES'(1));
  assign mask_left = take ? (step_q.mask & ~low) : step_q.mask;
  assign step_ready = (mask_left == '0);

  always_comb begin
    w_sel    = window;
    row_sel  = step_q.row - pos_t'(1);
    col_sel  = step_q.col - pos_t'(1);
    done_sel = 1'b0;
    priority if (step_q.mask[RES_MAIN]) begin
      w_sel = window;
    end else if (step_q.mask[RES_BELOW]) begin
      w_sel   = drop_row(window);
      row_sel = step_q.row;
    end else if (step_q.mask[RES_EDGE]) begin
      w_sel   = {3'b000, window[8:3]};
      col_sel = step_q.col;
    end else if (step_q.mask[RES_EDGE_BELOW]) begin
      w_sel    = drop_row({3'b000, window[8:3]});
      row_sel  = step_q.row;
      col_sel  = step_q.col;
      done_sel = 1'b1;
    end else begin
      w_sel = window;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_q.mask    <= '0;
      out_cell.valid <= 1'b0;
    end else begin
      if (load) begin
        step_q <= step_in;
      end else if (take) begin
        step_q.mask <= mask_left;
      end
      if (take) begin
        out_cell.valid <= 1'b1;
      end else if (out_cell.ready) begin
        out_cell.valid <= 1'b0;
      end
    end
  end

  // payload of the output register
  always_ff @(posedge clk) begin
    if (take) begin
      out_cell.next_alive <= life_next(w_sel);
      out_cell.out_row    <= row_sel[POS_W-1:0];
      out_cell.out_col    <= col_sel[POS_W-1:0];
      out_cell.frame_done <= done_sel;
    end
  end

endmodule

### hdl/life_automaton_generation_step_core.sv
// top level of the life generation step core: line chain, window, raster counters, apb regs
// depends on lca_pkg, lca_in_if, lca_out_if, lca_shift_cell and lca_drain
//
//  channel   dir  handshake        payload
//  in_cell   in   valid/ready      cell_alive
//  out_cell  out  valid/ready      next_alive, out_row, out_col, frame_done
//  apb       in   psel/penable     row_count at 0x0, col_count at 0x4
//
// an item moves the line chain and the window in its accept cycle; its results wait in the
// drain's pending register and pass into the output register once that register is free
// one item per cycle while each cell causes at most one result and out_cell is not stalled;
// a last-column or last-row cell holds the input until its extra results have left, the final
// cell until all four have, since the single output register drains the pending results
// rst clears counters, window and line chain; row_count and col_count return to 32
module life_automaton_generation_step_core
  import lca_pkg::*;
#(
  parameter int MAX_COLS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  lca_in_if.sink      in_cell,
  lca_out_if.source   out_cell
);

  localparam int             LINE_AW = $clog2(MAX_COLS);
  localparam logic [CNT_W-1:0] COL_LIM = CNT_W'(MAX_COLS);
  localparam int             RowLim  = (MAX_ROWS < 63) ? MAX_ROWS : 63;
  localparam logic [CNT_W-1:0] ROW_LIM = CNT_W'(RowLim);

  pos_t       row_count;
  pos_t       col_count;
  pos_t       in_row;
  pos_t       in_col;
  pos_t       rows;
  pos_t       cols;
  pos_t       cols_m1;
  pos_t       r;
  pos_t       c;
  logic       cfg_wr;
  logic       accept;
  logic       step_ready;
  logic       last_row;
  logic       last_col;
  logic       up1;
  logic       up2;
  logic [1:0] tap;
  logic [2:0] col_new;
  logic       col_restart;
  logic [8:0] window;
  step_t      step_in;
  logic [1:0] line_q [MAX_COLS];

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = {26'd0, (paddr[2] == REG_COL_COUNT) ? col_count : row_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= DIM_RESET;
      col_count <= DIM_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_ROW_COUNT: row_count <= pwdata[CNT_W-1:0];
        REG_COL_COUNT: col_count <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign rows = (row_count < MIN_DIM) ? MIN_DIM : ((row_count > ROW_LIM) ? ROW_LIM : row_count);
  assign cols = (col_count < MIN_DIM) ? MIN_DIM : ((col_count > COL_LIM) ? COL_LIM : col_count);
  assign cols_m1 = cols - pos_t'(1);

  // restart the raster if the counters fell outside a shrunken grid
  always_comb begin
    if ((in_row >= rows) || (in_col >= cols)) begin
      r = '0;
      c = '0;
    end else begin
      r = in_row;
      c = in_col;
    end
  end

  assign last_row = (r == rows - pos_t'(1));
  assign last_col = (c == cols_m1);

  assign in_cell.ready = step_ready;
  assign accept        = in_cell.valid && step_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row <= '0;
      in_col <= '0;
    end else if (cfg_wr) begin
      in_row <= '0;
      in_col <= '0;
    end else if (accept) begin
      if (last_col) begin
        in_col <= '0;
        in_row <= last_row ? '0 : r + pos_t'(1);
      end else begin
        in_row <= r;
        in_col <= c + pos_t'(1);
      end
    end
  end

  // the entry written one row ago has reached tap cols-1
  assign tap = line_q[cols_m1[LINE_AW-1:0]];
  assign up1 = (r >= pos_t'(1)) && tap[0];
  assign up2 = (r >= pos_t'(2)) && tap[1];

  for (genvar i = 0; i < MAX_COLS; i++) begin : g_line
    lca_shift_cell #(.W(2)) u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (accept),
      .clear (1'b0),
      .din   ((i == 0) ? {up1, in_cell.cell_alive} : line_q[(i == 0) ? 0 : i - 1]),
      .q     (line_q[i])
    );
  end

  assign col_new     = {up2, up1, in_cell.cell_alive};
  assign col_restart = cfg_wr || (c == '0);

  // window columns: [8:6] newest, [2:0] oldest
  lca_shift_cell #(.W(3)) u_win2 (
    .clk   (clk),
    .rst   (rst),
    .shift (accept || cfg_wr),
    .clear (cfg_wr),
    .din   (col_new),
    .q     (window[8:6])
  );

  lca_shift_cell #(.W(3)) u_win1 (
    .clk   (clk),
    .rst   (rst),
    .shift (accept || cfg_wr),
    .clear (col_restart),
    .din   (window[8:6]),
    .q     (window[5:3])
  );

  lca_shift_cell #(.W(3)) u_win0 (
    .clk   (clk),
    .rst   (rst),
    .shift (accept || cfg_wr),
    .clear (col_restart),
    .din   (window[5:3]),
    .q     (window[2:0])
  );

  always_comb begin
    step_in.row = r;
    step_in.col = c;
    step_in.mask[RES_MAIN]       = (r != '0) && (c != '0);
    step_in.mask[RES_BELOW]      = (r != '0) && (c != '0) && last_row;
    step_in.mask[RES_EDGE]       = (r != '0) && last_col;
    step_in.mask[RES_EDGE_BELOW] = (r != '0) && last_col && last_row;
  end

  lca_drain u_drain (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .step_in    (step_in),
    .window     (window),
    .step_ready (step_ready),
    .out_cell   (out_cell)
  );

endmodule

### dv/life_automaton_generation_step_core_tb.sv
// testbench for life_automaton_generation_step_core: streams raster cells of small and
// edge-size grids, predicts each next-generation cell under b3/s23 and checks the output
// depends on lca_pkg, lca_in_if, lca_out_if and the core itself
module life_automaton_generation_step_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lca_pkg::*;

  localparam int unsigned COL_MAX = 32;
  localparam int unsigned ITEM_TARGET = 430;

  typedef struct packed {
    logic       alive;
    logic [4:0] row;
    logic [4:0] col;
    logic       done;
  } gen_cell_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lca_in_if  in_bus ();
  lca_out_if out_bus ();

  life_automaton_generation_step_core u_top (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_cell  (in_bus),
    .out_cell (out_bus)
  );

  // predicted next-generation cells, oldest first
  gen_cell_t next_gen_q[$];

  // shadow of the core: two rows of history per column, 3x3 neighborhood, scan position
  logic [1:0]  col_hist [COL_MAX];
  logic [8:0]  nbhd;
  int unsigned scan_row;
  int unsigned scan_col;
  logic [5:0]  row_count_reg;
  logic [5:0]  col_count_reg;

  int unsigned errors;
  int unsigned items_sent;
  int unsigned cells_checked;
  int unsigned frames_seen;
  int unsigned gap_odds;
  int unsigned stall_odds;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("life_automaton_generation_step_core verification failed");
    $finish;
  end

  function automatic logic b3s23(logic [8:0] w);
    int n;
    n = $countones(w & 9'b111_101_111);
    return (n == 3) || ((n == 2) && w[4]);
  endfunction

  // every column moves down one row, a dead row comes in at the bottom
  function automatic logic [8:0] shift_down(logic [8:0] w);
    return (w << 1) & 9'b110_110_110;
  endfunction

  function automatic int unsigned eff_dim(logic [5:0] raw, int unsigned hi);
    if (raw < 3) return 3;
    if (raw > hi) return hi;
    return raw;
  endfunction

  task automatic push_cell(logic alive, int unsigned r, int unsigned c, logic done);
    gen_cell_t e;
    e.alive = alive;
    e.row   = r[4:0];
    e.col   = c[4:0];
    e.done  = done;
    next_gen_q.push_back(e);
  endtask

  task automatic step_grid(logic alive);
    int unsigned rows;
    int unsigned cols;
    int unsigned r;
    int unsigned c;
    logic        up1;
    logic        up2;
    logic [8:0]  side_w;
    bit          last_row;
    bit          last_col;
    rows = eff_dim(row_count_reg, MAX_ROWS);
    cols = eff_dim(col_count_reg, COL_MAX);
    if (scan_row >= rows || scan_col >= cols) begin
      scan_row = 0;
      scan_col = 0;
    end
    r = scan_row;
    c = scan_col;
    // history left from earlier rows or frames is dead at the top of the grid
    up1 = (r >= 1) ? col_hist[c][0] : 1'b0;
    up2 = (r >= 2) ? col_hist[c][1] : 1'b0;
    col_hist[c] = {up1, alive};
    if (c == 0) nbhd = {up2, up1, alive, 6'b0};
    else nbhd = {up2, up1, alive, nbhd[8:3]};
    last_row = (r == rows - 1);
    last_col = (c == cols - 1);
    if (r >= 1 && c >= 1) begin
      push_cell(b3s23(nbhd), r - 1, c - 1, 1'b0);
      if (last_row) push_cell(b3s23(shift_down(nbhd)), r, c - 1, 1'b0);
    end
    if (r >= 1 && last_col) begin
      side_w = {3'b000, nbhd[8:3]};
      push_cell(b3s23(side_w), r - 1, c, 1'b0);
      if (last_row) push_cell(b3s23(shift_down(side_w)), r, c, 1'b1);
    end
    if (last_col) begin
      scan_col = 0;
      scan_row = last_row ? 0 : r + 1;
    end else begin
      scan_col = c + 1;
    end
  endtask

  task automatic send_cell(logic alive);
    in_bus.valid      <= 1'b1;
    in_bus.cell_alive <= alive;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    step_grid(alive);
    items_sent++;
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic send_cells(int unsigned n, int unsigned pct_alive);
    repeat (n) send_cell($urandom_range(0, 99) < pct_alive);
  endtask

  // wait for every predicted cell, then let a cell with no result settle
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    while (next_gen_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_write_dim(logic idx, logic [5:0] val);
    logic [31:0] wdata;
    wdata      = $urandom();
    wdata[5:0] = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_ROW_COUNT) row_count_reg = val;
    else col_count_reg = val;
    // any write starts a new frame
    scan_row = 0;
    scan_col = 0;
    nbhd     = '0;
    // leave the bus idle before the next transfer
    @(posedge clk);
  endtask

  task automatic set_grid(logic [5:0] rows, logic [5:0] cols);
    apb_write_dim(REG_ROW_COUNT, rows);
    apb_write_dim(REG_COL_COUNT, cols);
  endtask

  function automatic int unsigned frame_cells();
    return eff_dim(row_count_reg, MAX_ROWS) * eff_dim(col_count_reg, COL_MAX);
  endfunction

  // geometry left by reset is 32x32: run into the second row
  task automatic test_reset_geometry();
    gap_odds   = 6;
    stall_odds = 8;
    send_cells(40, 50);
    drain_results();
  endtask

  task automatic test_directed_patterns();
    gap_odds   = 0;
    stall_odds = 0;
    set_grid(6'd3, 6'd3);
    // all alive: corners survive, the rest die of crowding
    repeat (9) send_cell(1'b1);
    // vertical blinker: side cells are born, ends die, center survives
    repeat (3) begin
      send_cell(1'b0);
      send_cell(1'b1);
      send_cell(1'b0);
    end
    drain_results();
  endtask

  task automatic test_register_saturation();
    gap_odds   = 5;
    stall_odds = 6;
    set_grid(6'd0, 6'd0);
    send_cells(frame_cells(), 60);
    drain_results();
    set_grid(6'd2, 6'd1);
    send_cells(frame_cells(), 40);
    drain_results();
    // tallest grid reaches row 31, widest reaches column 31
    set_grid(6'd63, 6'd2);
    send_cells(frame_cells(), 45);
    drain_results();
    set_grid(6'd1, 6'd33);
    send_cells(frame_cells(), 45);
    drain_results();
  endtask

  task automatic test_restart_mid_frame();
    gap_odds   = 7;
    stall_odds = 5;
    set_grid(6'd5, 6'd4);
    send_cells(13, 50);
    drain_results();
    apb_write_dim(REG_COL_COUNT, 6'd4);
    send_cells(frame_cells(), 50);
    drain_results();
    // shrink right after a full frame, stale history must read as dead
    apb_write_dim(REG_ROW_COUNT, 6'd3);
    send_cells(frame_cells(), 70);
    drain_results();
  endtask

  task automatic test_random_frames();
    logic [5:0]  rows;
    logic [5:0]  cols;
    int unsigned pct;
    int unsigned n;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent + 60 >= ITEM_TARGET) begin
        gap_odds   = 0;
        stall_odds = 0;
      end else begin
        gap_odds   = $urandom_range(0, 1) ? $urandom_range(2, 9) : 0;
        stall_odds = $urandom_range(0, 1) ? $urandom_range(2, 9) : 0;
      end
      if ($urandom_range(0, 11) == 0) begin
        rows = $urandom_range(0, 1) ? 6'd32 : 6'($urandom_range(33, 63));
        cols = 6'($urandom_range(3, 4));
        if ($urandom_range(0, 1)) {rows, cols} = {cols, rows};
      end else begin
        rows = 6'($urandom_range(0, 8));
        cols = 6'($urandom_range(0, 8));
      end
      set_grid(rows, cols);
      pct = $urandom_range(20, 65);
      n = frame_cells();
      if ($urandom_range(0, 5) == 0) begin
        // broken frame, the next write restarts it
        send_cells($urandom_range(1, n - 1), pct);
      end else begin
        // back-to-back generations without a write start over stale history
        repeat ($urandom_range(1, 2)) send_cells(n, pct);
      end
      drain_results();
    end
  endtask

  initial begin : out_ready_drive
    int stall;
    stall = 0;
    out_bus.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        stall--;
      end else begin
        out_bus.ready <= 1'b1;
        if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) stall = $urandom_range(1, 14);
      end
    end
  end

  always @(posedge clk) begin : check_cells
    gen_cell_t want;
    gen_cell_t got;
    if (!rst && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      got = {out_bus.next_alive, out_bus.out_row, out_bus.out_col, out_bus.frame_done};
      if (next_gen_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected cell alive %b row %0d col %0d done %b", $time,
                 got.alive, got.row, got.col, got.done);
      end else begin
        want = next_gen_q.pop_front();
        cells_checked++;
        if (got.done) frames_seen++;
        if (got !== want) begin
          errors++;
          $display("%0t: cell mismatch expected alive %b row %0d col %0d done %b, got alive %b row %0d col %0d done %b",
                   $time, want.alive, want.row, want.col, want.done,
                   got.alive, got.row, got.col, got.done);
        end
      end
    end
  end

  initial begin
    rst               <= 1'b1;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    in_bus.valid      <= 1'b0;
    in_bus.cell_alive <= 1'b0;
    for (int i = 0; i < COL_MAX; i++) col_hist[i] = 2'b00;
    nbhd          = '0;
    scan_row      = 0;
    scan_col      = 0;
    row_count_reg = DIM_RESET;
    col_count_reg = DIM_RESET;
    errors        = 0;
    items_sent    = 0;
    cells_checked = 0;
    frames_seen   = 0;
    gap_odds      = 0;
    stall_odds    = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_geometry();
    test_directed_patterns();
    test_register_saturation();
    test_restart_mid_frame();
    test_random_frames();

    if (next_gen_q.size() != 0) begin
      errors++;
      $display("%0t: %0d predicted cells never came out", $time, next_gen_q.size());
    end
    $display("streamed %0d cells, checked %0d next-state cells over %0d completed generations",
             items_sent, cells_checked, frames_seen);
    $display("grids from 3x3 to 32 rows and 32 columns, clamped sizes and mid-frame restarts");
    if (errors == 0) begin
      $display("life_automaton_generation_step_core verification clean");
    end else begin
      $display("life_automaton_generation_step_core verification failed");
    end
    $finish;
  end

endmodule

### files.f
hdl/lca_pkg.sv
hdl/lca_in_if.sv
hdl/lca_out_if.sv
hdl/lca_shift_cell.sv
hdl/lca_drain.sv
hdl/life_automaton_generation_step_core.sv
dv/life_automaton_generation_step_core_tb.sv
